@@ rtl/jse_pkg.sv @@
// ----------------------------------------------------------------------------
// jse_pkg
// shared types, codes and character helpers for the json string escaper
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

    // width of the saturating character count
    localparam int COUNT_WIDTH = 32;
    localparam int CAP_WIDTH   = 32;
    localparam int LEN_WIDTH   = 32;

    // descriptor queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // opcodes of the input channel
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_BYTE  = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    // descriptor classes
    localparam logic [1:0] CLS_START  = 2'd0;
    localparam logic [1:0] CLS_SINGLE = 2'd1;
    localparam logic [1:0] CLS_ESC2   = 2'd2;
    localparam logic [1:0] CLS_UNI    = 2'd3;

    // characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6e;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [3:0] NIBBLE_MASK = 4'hf;

    // control byte codes with short escapes
    localparam logic [7:0] BYTE_BS = 8'h08;
    localparam logic [7:0] BYTE_HT = 8'h09;
    localparam logic [7:0] BYTE_LF = 8'h0a;
    localparam logic [7:0] BYTE_FF = 8'h0c;
    localparam logic [7:0] BYTE_CR = 8'h0d;

    // characters per class
    localparam int UNI_LEN = 6;
    localparam int STEP_W  = $clog2(UNI_LEN);
    localparam logic [STEP_W-1:0] STEP_ESC2_LAST = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_UNI_LAST  = STEP_W'(UNI_LEN - 1);

    typedef struct packed {
        logic [1:0] cls;
        logic [7:0] ch;
    } desc_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [3:0] n;
        n = v & NIBBLE_MASK;
        if (n < 4'd10) begin
            hex_digit = CH_ZERO + {4'd0, n};
        end else begin
            hex_digit = CH_LOW_A - 8'd10 + {4'd0, n};
        end
    endfunction

    function automatic logic [STEP_W-1:0] last_step(input logic [1:0] cls);
        case (cls)
            CLS_ESC2: last_step = STEP_ESC2_LAST;
            CLS_UNI:  last_step = STEP_UNI_LAST;
            default:  last_step = '0;
        endcase
    endfunction

    // character at a given step of a descriptor's output run
    function automatic logic [7:0] run_char(input desc_t d, input logic [STEP_W-1:0] step);
        logic [7:0] c;
        c = d.ch;
        case (d.cls)
            CLS_ESC2: begin
                c = (step == '0) ? CH_BSLASH : d.ch;
            end
            CLS_UNI: begin
                case (step)
                    STEP_W'(0): c = CH_BSLASH;
                    STEP_W'(1): c = CH_LOW_U;
                    STEP_W'(2): c = CH_ZERO;
                    STEP_W'(3): c = CH_ZERO;
                    STEP_W'(4): c = d.ch[4] ? CH_ONE : CH_ZERO;
                    default:    c = hex_digit(d.ch[3:0]);
                endcase
            end
            default: begin
                c = d.ch;
            end
        endcase
        run_char = c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/jse_front.sv @@
// ----------------------------------------------------------------------------
// jse_front
// accepts input items and classifies them into run descriptors
// ----------------------------------------------------------------------------
`default_nettype none

module jse_front (
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_opcode,
    input  wire logic [7:0]        s_data_byte,
    input  wire logic              q_full,
    output logic                   q_push,
    output jse_pkg::desc_t         q_desc
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_desc.cls = jse_pkg::CLS_SINGLE;
        q_desc.ch  = jse_pkg::CH_QUOTE;
        case (s_opcode)
            jse_pkg::OP_START: begin
                q_desc.cls = jse_pkg::CLS_START;
            end
            jse_pkg::OP_BEGIN, jse_pkg::OP_END: begin
                q_desc.cls = jse_pkg::CLS_SINGLE;
                q_desc.ch  = jse_pkg::CH_QUOTE;
            end
            jse_pkg::OP_BYTE: begin
                q_desc.cls = jse_pkg::CLS_ESC2;
                case (s_data_byte)
                    jse_pkg::CH_QUOTE:  q_desc.ch = jse_pkg::CH_QUOTE;
                    jse_pkg::CH_BSLASH: q_desc.ch = jse_pkg::CH_BSLASH;
                    jse_pkg::BYTE_BS:   q_desc.ch = jse_pkg::CH_LOW_B;
                    jse_pkg::BYTE_FF:   q_desc.ch = jse_pkg::CH_LOW_F;
                    jse_pkg::BYTE_LF:   q_desc.ch = jse_pkg::CH_LOW_N;
                    jse_pkg::BYTE_CR:   q_desc.ch = jse_pkg::CH_LOW_R;
                    jse_pkg::BYTE_HT:   q_desc.ch = jse_pkg::CH_LOW_T;
                    default: begin
                        // other control bytes take the long form, all other bytes pass as is
                        q_desc.ch  = s_data_byte;
                        q_desc.cls = (s_data_byte < jse_pkg::CTRL_LIMIT) ?
                                     jse_pkg::CLS_UNI : jse_pkg::CLS_SINGLE;
                    end
                endcase
            end
            default: begin
                q_desc.cls = jse_pkg::CLS_SINGLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/jse_queue.sv @@
// ----------------------------------------------------------------------------
// jse_queue
// short register queue of run descriptors between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module jse_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire jse_pkg::desc_t   push_desc,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output jse_pkg::desc_t        head_desc
);

    jse_pkg::desc_t entry_reg [jse_pkg::QUEUE_DEPTH];

    logic [jse_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [jse_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [jse_pkg::QPTR_W:0]   count_reg, count_next;

    localparam logic [jse_pkg::QPTR_W:0] DEPTH_CNT = (jse_pkg::QPTR_W + 1)'(jse_pkg::QUEUE_DEPTH);

    assign full       = (count_reg == DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head_desc  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // no push into a full queue, no pop from an empty one
    assert property (@(posedge aclk) disable iff (!aresetn) !(push && full))
        else $error("queue push while full");
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> head_valid)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

@@ rtl/jse_back.sv @@
// ----------------------------------------------------------------------------
// jse_back
// expands run descriptors into characters, counts and tracks buffer room
// ----------------------------------------------------------------------------
`default_nettype none

module jse_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [jse_pkg::CAP_WIDTH-1:0]  cfg_wr_data,
    input  wire logic                           head_valid,
    input  wire jse_pkg::desc_t                 head_desc,
    output logic                                pop,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [7:0]                          m_out_char,
    output logic                                m_kept,
    output logic [jse_pkg::LEN_WIDTH-1:0]       m_total_length,
    output logic                                m_last_of_run
);

    localparam logic [jse_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [jse_pkg::CAP_WIDTH-1:0]   cap_reg;
    logic [jse_pkg::COUNT_WIDTH-1:0] count_reg, count_next, count_inc;
    logic [jse_pkg::CAP_WIDTH-1:0]   room_reg, room_next;
    logic                            storing_reg, storing_next;
    logic [jse_pkg::STEP_W-1:0]      step_reg, step_next;
    logic                            m_valid_reg, m_valid_next;
    logic [7:0]                      char_reg;
    logic                            kept_reg;
    logic [jse_pkg::LEN_WIDTH-1:0]   len_reg;
    logic                            last_reg;

    logic advance, is_start, start_fire, emit, run_last, fits;

    assign advance    = !m_valid_reg || m_ready;
    assign is_start   = (head_desc.cls == jse_pkg::CLS_START);
    assign start_fire = head_valid && is_start;
    assign emit       = head_valid && !is_start && advance;
    assign run_last   = (step_reg == jse_pkg::last_step(head_desc.cls));
    assign pop        = start_fire || (emit && run_last);
    assign fits       = storing_reg && (room_reg > jse_pkg::CAP_WIDTH'(1));
    assign count_inc  = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;

    always_comb begin
        count_next   = count_reg;
        room_next    = room_reg;
        storing_next = storing_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (start_fire) begin
            count_next   = '0;
            room_next    = cap_reg;
            storing_next = 1'b1;
        end else if (emit) begin
            count_next   = count_inc;
            m_valid_next = 1'b1;
            step_next    = run_last ? '0 : step_reg + 1'b1;
            if (fits) begin
                room_next = room_reg - 1'b1;
            end else begin
                storing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= '0;
            count_reg   <= '0;
            room_reg    <= '0;
            storing_reg <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            count_reg   <= count_next;
            room_reg    <= room_next;
            storing_reg <= storing_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            char_reg <= jse_pkg::run_char(head_desc, step_reg);
            kept_reg <= fits;
            len_reg  <= jse_pkg::LEN_WIDTH'(count_inc);
            last_reg <= run_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_char     = char_reg;
    assign m_kept         = kept_reg;
    assign m_total_length = len_reg;
    assign m_last_of_run  = last_reg;

    // once storing is off nothing is kept until a start
    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !storing_reg) |=> !m_kept)
        else $error("character kept while storing off");
    // count steps by one per character below saturation
    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && count_reg != COUNT_MAX) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("count did not advance");
    // run step never passes the longest escape
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= jse_pkg::STEP_UNI_LAST)
        else $error("run step out of range");

endmodule

`default_nettype wire

@@ rtl/json_string_escaper_top.sv @@
// ----------------------------------------------------------------------------
// json_string_escaper_top
// streaming json string escaper with saturating length and buffer tracking
// ----------------------------------------------------------------------------
// Items arrive on the s_ channel (opcode plus raw byte) and escaped characters
// leave on the m_ channel, one character per transfer, with a kept flag, the
// running total length and a marker on the last character of each item. A
// plain byte or a quote item gives one character and the block sustains one
// character per cycle while m_ready stays high; a short escape expands to a
// backslash and one letter and a \u00xx escape to six characters, which the
// back end makes one per cycle. A start item gives no transfer. The
// front end keeps taking items while the back end expands an escape until
// the 2-entry descriptor queue between them fills, so s_ready drops only then.
// Items pass the queue and the output register. The user must write the buffer
// capacity register through cfg_wr_en/cfg_wr_data only while idle, which the
// block does not enforce; each start item loads it into the room counter.
`default_nettype none

module json_string_escaper_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // configuration write
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,

    // item input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [7:0]  s_data_byte,

    // character output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_char,
    output logic             m_kept,
    output logic [31:0]      m_total_length,
    output logic             m_last_of_run
);

    // descriptor path: front -> queue -> back
    jse_pkg::desc_t push_desc;
    jse_pkg::desc_t head_desc;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           head_valid;

    // classify the item into a run descriptor
    jse_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_data_byte (s_data_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_desc      (push_desc)
    );

    // decouples item intake from character expansion
    jse_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    // one character per cycle while m_ready allows, counters and output register
    jse_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .head_valid     (head_valid),
        .head_desc      (head_desc),
        .pop            (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_char     (m_out_char),
        .m_kept         (m_kept),
        .m_total_length (m_total_length),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

`default_nettype wire
